// ----- rtl/vwna_pkg.sv -----
package vwna_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MERGE,
        S_READ_RD,
        S_READ_DAT,
        S_DIV,
        S_OUT
    } state_t;

    localparam int POS_W   = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int THR_W   = 31;
    localparam int IDX_W   = 8;
    localparam logic [THR_W-1:0] THRESH_RESET = 31'd66;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

// ----- rtl/vertex_weld_normal_average.sv -----
// Vertex welder. An insert (kind 0) scans the stored unique positions entry by entry
// (synchronous read, then compare) until the first entry whose per-axis distance is
// strictly below match_threshold, then either accumulates the normal into that entry
// unless its count is saturated, or appends a new entry, or reports full. A read (kind 1)
// returns the position and the normal sums divided by the merge count through a
// restoring divider of 48 steps, one per cycle, for the three axes in parallel, or a
// range status if the entry is not below the fill count. A clear (kind 2) resets the
// fill count. The table memory needs no clearing pass; entries are valid only below
// the fill count. One item at a time; the result sits in an output register until its transfer.
module vertex_weld_normal_average #(
    parameter int UNIQUE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_norm_x,
    input  logic signed [31:0] s_norm_y,
    input  logic signed [31:0] s_norm_z,
    input  logic [7:0]  s_entry_sel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_unique_index,
    output logic        m_is_new,
    output logic [1:0]  m_status,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_pos_z,
    output logic signed [31:0] m_avg_norm_x,
    output logic signed [31:0] m_avg_norm_y,
    output logic signed [31:0] m_avg_norm_z,
    output logic [15:0] m_ref_count
);

    localparam int AW  = (UNIQUE_DEPTH > 1) ? $clog2(UNIQUE_DEPTH) : 1;
    localparam int UW  = $clog2(UNIQUE_DEPTH + 1);
    localparam int SW  = vwna_pkg::SUM_W;
    localparam int DCW = $clog2(SW + 1);

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [SW-1:0] sx, sy, sz;
        logic [15:0] cnt;
    } entry_t;

    entry_t mem [UNIQUE_DEPTH];
    entry_t rd_q;
    entry_t wr_d;
    logic        wr_en;
    logic [AW-1:0] wr_a, rd_a;

    vwna_pkg::state_t state_reg, state_next;
    logic [30:0] thr_reg;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] ptr_reg, ptr_next;
    logic signed [31:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic [7:0]  sel_reg;

    // divider
    logic [SW-1:0] q_reg [3];
    logic [SW:0]   r_reg [3];
    logic          neg_reg [3];
    logic [SW-1:0] q_next [3];
    logic [SW:0]   r_next [3];
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [15:0]   div_reg;

    logic        mv_reg, mv_next;
    logic [7:0]  o_idx_reg, o_idx_next;
    logic        o_new_reg, o_new_next;
    logic [1:0]  o_st_reg, o_st_next;
    entry_t      o_ent_reg, o_ent_next;
    logic        ld_div;

    function automatic logic near(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input logic [30:0] t);
        logic signed [32:0] d;
        logic [32:0] m;
        d = 33'(a) - 33'(b);
        m = d[32] ? 33'(-d) : 33'(d);
        return m < {2'b00, t};
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_a] <= wr_d;
        end
        rd_q <= mem[rd_a];
    end

    logic hit;
    assign hit = near(rd_q.px, px_reg, thr_reg) && near(rd_q.py, py_reg, thr_reg)
              && near(rd_q.pz, pz_reg, thr_reg);

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        ptr_next   = ptr_reg;
        mv_next    = mv_reg;
        o_idx_next = o_idx_reg;
        o_new_next = o_new_reg;
        o_st_next  = o_st_reg;
        o_ent_next = o_ent_reg;
        wr_en      = 1'b0;
        wr_a       = ptr_reg[AW-1:0];
        wr_d       = rd_q;
        rd_a       = ptr_reg[AW-1:0];
        ld_div     = 1'b0;
        s_ready    = (state_reg == vwna_pkg::S_IDLE) && !mv_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            vwna_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    ptr_next   = '0;
                    o_idx_next = '0;
                    o_new_next = 1'b0;
                    o_st_next  = vwna_pkg::ST_OK;
                    o_ent_next = '0;
                    unique case (vwna_pkg::kind_t'(s_kind))
                        vwna_pkg::KIND_INSERT: state_next = vwna_pkg::S_SCAN_RD;
                        vwna_pkg::KIND_READ: begin
                            ptr_next   = UW'(s_entry_sel);
                            state_next = vwna_pkg::S_READ_RD;
                        end
                        vwna_pkg::KIND_CLEAR: begin
                            used_next  = '0;
                            state_next = vwna_pkg::S_OUT;
                        end
                        default: state_next = vwna_pkg::S_OUT;
                    endcase
                end
            end
            vwna_pkg::S_SCAN_RD: begin
                if (ptr_reg >= used_reg) begin
                    if (used_reg < UW'(UNIQUE_DEPTH)) begin
                        wr_en      = 1'b1;
                        wr_a       = used_reg[AW-1:0];
                        wr_d       = '{px: px_reg, py: py_reg, pz: pz_reg,
                                       sx: SW'(nx_reg), sy: SW'(ny_reg), sz: SW'(nz_reg),
                                       cnt: 16'd1};
                        o_idx_next = 8'(used_reg);
                        o_new_next = 1'b1;
                        used_next  = used_reg + 1'b1;
                    end else begin
                        o_st_next = vwna_pkg::ST_FULL;
                    end
                    state_next = vwna_pkg::S_OUT;
                end else begin
                    state_next = vwna_pkg::S_SCAN_CMP;
                end
            end
            vwna_pkg::S_SCAN_CMP: begin
                if (hit) begin
                    state_next = vwna_pkg::S_MERGE;
                end else begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = vwna_pkg::S_SCAN_RD;
                end
            end
            vwna_pkg::S_MERGE: begin
                if (rd_q.cnt != vwna_pkg::COUNT_MAX) begin
                    wr_en    = 1'b1;
                    wr_d.cnt = rd_q.cnt + 16'd1;
                    wr_d.sx  = rd_q.sx + SW'(nx_reg);
                    wr_d.sy  = rd_q.sy + SW'(ny_reg);
                    wr_d.sz  = rd_q.sz + SW'(nz_reg);
                end
                o_idx_next = 8'(ptr_reg);
                state_next = vwna_pkg::S_OUT;
            end
            vwna_pkg::S_READ_RD: begin
                o_idx_next = sel_reg;
                if ({24'd0, sel_reg} < 32'(used_reg)) begin
                    state_next = vwna_pkg::S_READ_DAT;
                end else begin
                    o_st_next  = vwna_pkg::ST_RANGE;
                    state_next = vwna_pkg::S_OUT;
                end
            end
            vwna_pkg::S_READ_DAT: begin
                ld_div     = 1'b1;
                o_ent_next = rd_q;
                state_next = vwna_pkg::S_DIV;
            end
            vwna_pkg::S_DIV: begin
                if (dcnt_reg == '0) begin
                    o_ent_next.sx = neg_reg[0] ? -q_reg[0] : q_reg[0];
                    o_ent_next.sy = neg_reg[1] ? -q_reg[1] : q_reg[1];
                    o_ent_next.sz = neg_reg[2] ? -q_reg[2] : q_reg[2];
                    state_next    = vwna_pkg::S_OUT;
                end
            end
            vwna_pkg::S_OUT: begin
                mv_next    = 1'b1;
                state_next = vwna_pkg::S_IDLE;
            end
            default: state_next = vwna_pkg::S_IDLE;
        endcase
    end

    logic [SW-1:0] mag [3];
    assign mag[0] = rd_q.sx[SW-1] ? -rd_q.sx : rd_q.sx;
    assign mag[1] = rd_q.sy[SW-1] ? -rd_q.sy : rd_q.sy;
    assign mag[2] = rd_q.sz[SW-1] ? -rd_q.sz : rd_q.sz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [SW:0] t;
            t = {r_reg[a][SW-1:0], q_reg[a][SW-1]};
            if (t >= {{(SW-15){1'b0}}, div_reg}) begin
                r_next[a] = t - {{(SW-15){1'b0}}, div_reg};
                q_next[a] = {q_reg[a][SW-2:0], 1'b1};
            end else begin
                r_next[a] = t;
                q_next[a] = {q_reg[a][SW-2:0], 1'b0};
            end
        end
        dcnt_next = dcnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (ld_div) begin
            for (int a = 0; a < 3; a++) begin
                q_reg[a] <= mag[a];
                r_reg[a] <= '0;
            end
            neg_reg[0] <= rd_q.sx[SW-1];
            neg_reg[1] <= rd_q.sy[SW-1];
            neg_reg[2] <= rd_q.sz[SW-1];
            div_reg    <= (rd_q.cnt == '0) ? 16'd1 : rd_q.cnt;
            dcnt_reg   <= DCW'(SW);
        end else if (state_reg == vwna_pkg::S_DIV && dcnt_reg != '0) begin
            for (int a = 0; a < 3; a++) begin
                q_reg[a] <= q_next[a];
                r_reg[a] <= r_next[a];
            end
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vwna_pkg::S_IDLE;
            thr_reg   <= vwna_pkg::THRESH_RESET;
            used_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        o_idx_reg <= o_idx_next;
        o_new_reg <= o_new_next;
        o_st_reg  <= o_st_next;
        o_ent_reg <= o_ent_next;
        if (s_valid && s_ready) begin
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
            pz_reg <= s_pos_z;
            nx_reg <= s_norm_x;
            ny_reg <= s_norm_y;
            nz_reg <= s_norm_z;
            sel_reg <= s_entry_sel;
        end
    end

    assign m_valid        = mv_reg;
    assign m_unique_index = o_idx_reg;
    assign m_is_new       = o_new_reg;
    assign m_status       = o_st_reg;
    assign m_out_pos_x    = o_ent_reg.px;
    assign m_out_pos_y    = o_ent_reg.py;
    assign m_out_pos_z    = o_ent_reg.pz;
    assign m_avg_norm_x   = o_ent_reg.sx[31:0];
    assign m_avg_norm_y   = o_ent_reg.sy[31:0];
    assign m_avg_norm_z   = o_ent_reg.sz[31:0];
    assign m_ref_count    = o_ent_reg.cnt;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(UNIQUE_DEPTH)) else $error("fill count over depth");
    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_new) |-> m_status == vwna_pkg::ST_OK) else $error("new with error");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != vwna_pkg::S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg > $past(used_reg)) |-> $past(state_reg) == vwna_pkg::S_SCAN_RD)
        else $error("fill count grew outside insert");

endmodule
